FILE: src/arpr_pkg.sv
package arpr_pkg;

   localparam int CACHE_ENTRIES_DEF   = 16;
   localparam int REQUEST_ENTRIES_DEF = 16;
   localparam int PENDING_DEPTH_DEF   = 16;
   localparam int MAX_RESULTS         = 16;
   localparam int RES_CNT_W           = $clog2(MAX_RESULTS + 1);
   localparam int QUEUE_DEPTH         = 2;

   localparam logic [1:0] MODE_SEND = 2'd0;
   localparam logic [1:0] MODE_RECV = 2'd1;
   localparam logic [1:0] MODE_TICK = 2'd2;
   localparam logic [1:0] MODE_NONE = 2'd3;

   localparam logic [15:0] ETH_IPV4   = 16'h0800;
   localparam logic [15:0] ETH_ARP    = 16'h0806;
   localparam logic [15:0] ARP_OP_REQ = 16'd1;
   localparam logic [15:0] ARP_OP_REP = 16'd2;
   localparam logic [47:0] BCAST_MAC  = 48'hFFFF_FFFF_FFFF;

   localparam logic [1:0] KIND_IPV4_OUT = 2'd0;
   localparam logic [1:0] KIND_ARP_REQ  = 2'd1;
   localparam logic [1:0] KIND_ARP_REP  = 2'd2;
   localparam logic [1:0] KIND_DELIVER  = 2'd3;

   localparam logic [1:0] CSR_OWN_MAC  = 2'd0;
   localparam logic [1:0] CSR_OWN_IP   = 2'd1;
   localparam logic [1:0] CSR_LIFETIME = 2'd2;
   localparam logic [1:0] CSR_HOLDOFF  = 2'd3;

   localparam logic [31:0] LIFETIME_RST = 32'd30000;
   localparam logic [31:0] HOLDOFF_RST  = 32'd5000;

   typedef struct packed {
      logic [1:0]  mode;
      logic [31:0] gateway_ip;
      logic [15:0] packet_tag;
      logic [47:0] frame_dst_mac;
      logic [15:0] frame_ether_type;
      logic        payload_ok;
      logic [15:0] arp_opcode;
      logic [47:0] arp_sender_mac;
      logic [31:0] arp_sender_ip;
      logic [31:0] arp_target_ip;
      logic [31:0] elapsed_ms;
   } req_type;

   typedef struct packed {
      logic [1:0]  result_kind;
      logic [47:0] out_dst_mac;
      logic [31:0] out_target_ip;
      logic [47:0] out_target_mac;
      logic [15:0] out_tag;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [47:0] own_mac;
      logic [31:0] own_ip;
      logic [31:0] cache_lifetime_ms;
      logic [31:0] request_holdoff_ms;
   } cfg_type;

   typedef enum logic [1:0] {
      OP_SEND,
      OP_DELIVER,
      OP_LEARN,
      OP_TICK
   } op_type;

   typedef struct packed {
      op_type      op;
      logic [31:0] ip;
      logic [15:0] tag;
      logic [47:0] mac;
      logic        reply_us;
      logic        req_us;
      logic [31:0] elapsed;
   } item_type;

   typedef enum logic [2:0] {
      B_IDLE,
      B_SCAN,
      B_DECIDE,
      B_EMIT,
      B_DRN_RD,
      B_DRN_CMP,
      B_DRN_FIN
   } back_state_type;

endpackage

FILE: src/arpr_front.sv
module arpr_front import arpr_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  cfg_type  cfg,
   input  logic     req_valid,
   output logic     req_ready,
   input  req_type  req_data,
   output logic     item_valid,
   input  logic     item_ready,
   output item_type item
);

   logic     fv_ff, fv_in;
   item_type item_ff, item_in;
   item_type cls;
   logic     keep;
   logic     dst_ok;
   logic     accept;

   always_comb begin
      cls = '0;
      keep = 1'b0;
      dst_ok = (req_data.frame_dst_mac == BCAST_MAC) || (req_data.frame_dst_mac == cfg.own_mac);
      unique case (req_data.mode)
         MODE_SEND: begin
            keep = 1'b1;
            cls.op = OP_SEND;
            cls.ip = req_data.gateway_ip;
            cls.tag = req_data.packet_tag;
         end
         MODE_RECV: begin
            if (dst_ok && req_data.payload_ok) begin
               if (req_data.frame_ether_type == ETH_IPV4) begin
                  keep = 1'b1;
                  cls.op = OP_DELIVER;
                  cls.tag = req_data.packet_tag;
               end else if (req_data.frame_ether_type == ETH_ARP) begin
                  keep = 1'b1;
                  cls.op = OP_LEARN;
                  cls.ip = req_data.arp_sender_ip;
                  cls.mac = req_data.arp_sender_mac;
                  cls.reply_us = (req_data.arp_opcode == ARP_OP_REP)
                                 && (req_data.arp_target_ip == cfg.own_ip);
                  cls.req_us = (req_data.arp_opcode == ARP_OP_REQ)
                               && (req_data.arp_target_ip == cfg.own_ip);
               end
            end
         end
         MODE_TICK: begin
            keep = 1'b1;
            cls.op = OP_TICK;
            cls.elapsed = req_data.elapsed_ms;
         end
         default: keep = 1'b0;
      endcase
   end

   assign req_ready = !fv_ff || item_ready;
   assign accept = req_valid && req_ready;

   always_comb begin
      if (accept) begin
         fv_in = keep;
         item_in = cls;
      end else begin
         fv_in = fv_ff && !item_ready;
         item_in = item_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fv_ff <= 1'b0;
      end else begin
         fv_ff <= fv_in;
      end
      item_ff <= item_in;
   end

   assign item_valid = fv_ff;
   assign item = item_ff;

endmodule

FILE: src/arpr_fifo.sv
module arpr_fifo import arpr_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_ready,
   input  item_type in_item,
   output logic     out_valid,
   input  logic     out_ready,
   output item_type out_item
);

   localparam int AW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   item_type        mem_ff [QUEUE_DEPTH];
   logic [AW-1:0]   wr_ff, wr_in, rd_ff, rd_in;
   logic [CW-1:0]   cnt_ff, cnt_in;
   logic            push, pop;

   assign in_ready = cnt_ff != CW'(QUEUE_DEPTH);
   assign out_valid = cnt_ff != '0;
   assign out_item = mem_ff[rd_ff];
   assign push = in_valid && in_ready;
   assign pop = out_valid && out_ready;

   always_comb begin
      wr_in = wr_ff;
      rd_in = rd_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in = (wr_ff == AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (pop) begin
         rd_in = (rd_ff == AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         mem_ff[wr_ff] <= in_item;
      end
   end

endmodule

FILE: src/arpr_back.sv
module arpr_back import arpr_pkg::*; #(
   parameter int CACHE_ENTRIES   = CACHE_ENTRIES_DEF,
   parameter int REQUEST_ENTRIES = REQUEST_ENTRIES_DEF,
   parameter int PENDING_DEPTH   = PENDING_DEPTH_DEF
) (
   input  logic     clock,
   input  logic     reset,
   input  cfg_type  cfg,
   input  logic     item_valid,
   output logic     item_ready,
   input  item_type item,
   output logic     rsp_valid,
   input  logic     rsp_ready,
   output rsp_type  rsp_data
);

   localparam int CI_W = $clog2(CACHE_ENTRIES);
   localparam int RI_W = $clog2(REQUEST_ENTRIES);
   localparam int PI_W = $clog2(PENDING_DEPTH);
   localparam int PC_W = $clog2(PENDING_DEPTH + 1);
   localparam int MAXE = (CACHE_ENTRIES > REQUEST_ENTRIES) ? CACHE_ENTRIES : REQUEST_ENTRIES;
   localparam int MI_W = $clog2(MAXE);
   localparam int SC_W = $clog2(MAXE + 1);

   function automatic rsp_type make_rsp(logic [1:0] kind, logic [47:0] dst, logic [31:0] tip,
                                        logic [47:0] tmac, logic [15:0] tag, logic lst);
      rsp_type r;
      r.result_kind = kind;
      r.out_dst_mac = dst;
      r.out_target_ip = tip;
      r.out_target_mac = tmac;
      r.out_tag = tag;
      r.last = lst;
      return r;
   endfunction

   back_state_type state_ff, state_in;
   item_type       cur_ff, cur_in;
   logic [47:0]    now_ff, now_in;

   logic [31:0] c_ip_mem  [CACHE_ENTRIES];
   logic [47:0] c_mac_mem [CACHE_ENTRIES];
   logic [47:0] c_st_mem  [CACHE_ENTRIES];
   logic [CACHE_ENTRIES-1:0] c_valid_ff;
   logic [31:0] c_rd_ip_ff;
   logic [47:0] c_rd_mac_ff, c_rd_st_ff;

   logic [31:0] r_ip_mem [REQUEST_ENTRIES];
   logic [47:0] r_st_mem [REQUEST_ENTRIES];
   logic [REQUEST_ENTRIES-1:0] r_valid_ff;
   logic [31:0] r_rd_ip_ff;
   logic [47:0] r_rd_st_ff;

   logic [31:0] p_ip_mem  [PENDING_DEPTH];
   logic [15:0] p_tag_mem [PENDING_DEPTH];
   logic [31:0] p_rd_ip_ff;
   logic [15:0] p_rd_tag_ff;
   logic [PI_W-1:0] head_ff, head_in, tail_ff, tail_in;
   logic [PC_W-1:0] cnt_ff, cnt_in;

   logic [SC_W-1:0] sc_cnt_ff, sc_cnt_in;
   logic            sc_req_ff, sc_req_in;
   logic            hit_ff, hit_in, free_ff, free_in, old_ff, old_in;
   logic [MI_W-1:0] hit_idx_ff, hit_idx_in, free_idx_ff, free_idx_in, old_idx_ff, old_idx_in;
   logic [47:0]     hit_st_ff, hit_st_in, hit_mac_ff, hit_mac_in, old_st_ff, old_st_in;

   logic [RES_CNT_W-1:0] nres_ff, nres_in;
   logic                 held_ff, held_in;
   logic [15:0]          held_tag_ff, held_tag_in;
   rsp_type              res_ff, res_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_ff, rsp_in;

   logic            out_free, out_load;
   rsp_type         out_data;
   logic [SC_W-1:0] e_w, n_ent;
   logic            e_v;
   logic [31:0]     e_ip;
   logic [47:0]     e_st;
   logic [MI_W-1:0] slot;
   logic            c_we, c_clr, r_we, p_push, p_pop;
   logic [CI_W-1:0] c_waddr, c_clr_idx;
   logic [RI_W-1:0] r_waddr;
   logic [48:0]     now_sum;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign n_ent = sc_req_ff ? SC_W'(REQUEST_ENTRIES) : SC_W'(CACHE_ENTRIES);
   assign e_w = sc_cnt_ff - 1'b1;
   assign e_v = sc_req_ff ? r_valid_ff[e_w[RI_W-1:0]] : c_valid_ff[e_w[CI_W-1:0]];
   assign e_ip = sc_req_ff ? r_rd_ip_ff : c_rd_ip_ff;
   assign e_st = sc_req_ff ? r_rd_st_ff : c_rd_st_ff;
   assign slot = hit_ff ? hit_idx_ff : (free_ff ? free_idx_ff : old_idx_ff);
   assign now_sum = 49'(now_ff) + 49'(item.elapsed);
   assign item_ready = state_ff == B_IDLE;

   always_comb begin
      state_in = state_ff;
      cur_in = cur_ff;
      now_in = now_ff;
      sc_cnt_in = sc_cnt_ff;
      sc_req_in = sc_req_ff;
      hit_in = hit_ff;
      hit_idx_in = hit_idx_ff;
      hit_st_in = hit_st_ff;
      hit_mac_in = hit_mac_ff;
      free_in = free_ff;
      free_idx_in = free_idx_ff;
      old_in = old_ff;
      old_idx_in = old_idx_ff;
      old_st_in = old_st_ff;
      nres_in = nres_ff;
      held_in = held_ff;
      held_tag_in = held_tag_ff;
      res_in = res_ff;
      out_load = 1'b0;
      out_data = res_ff;
      c_we = 1'b0;
      c_waddr = slot[CI_W-1:0];
      c_clr = 1'b0;
      c_clr_idx = e_w[CI_W-1:0];
      r_we = 1'b0;
      r_waddr = slot[RI_W-1:0];
      p_push = 1'b0;
      p_pop = 1'b0;
      unique case (state_ff)
         B_IDLE: begin
            if (item_valid) begin
               cur_in = item;
               sc_cnt_in = '0;
               sc_req_in = 1'b0;
               hit_in = 1'b0;
               free_in = 1'b0;
               old_in = 1'b0;
               case (item.op)
                  OP_DELIVER: begin
                     res_in = make_rsp(KIND_DELIVER, '0, '0, '0, item.tag, 1'b1);
                     state_in = B_EMIT;
                  end
                  OP_TICK: begin
                     now_in = now_sum[48] ? '1 : now_sum[47:0];
                     state_in = B_SCAN;
                  end
                  default: state_in = B_SCAN;
               endcase
            end
         end
         B_SCAN: begin
            if (sc_cnt_ff != '0) begin
               if (cur_ff.op == OP_TICK) begin
                  c_clr = e_v && ((49'(e_st) + 49'(cfg.cache_lifetime_ms)) <= 49'(now_ff));
               end else begin
                  if (e_v && e_ip == cur_ff.ip && !hit_ff) begin
                     hit_in = 1'b1;
                     hit_idx_in = e_w[MI_W-1:0];
                     hit_st_in = e_st;
                     hit_mac_in = c_rd_mac_ff;
                  end
                  if (!e_v && !free_ff) begin
                     free_in = 1'b1;
                     free_idx_in = e_w[MI_W-1:0];
                  end
                  if (e_v && (!old_ff || e_st < old_st_ff)) begin
                     old_in = 1'b1;
                     old_idx_in = e_w[MI_W-1:0];
                     old_st_in = e_st;
                  end
               end
            end
            if (sc_cnt_ff == n_ent) begin
               state_in = (cur_ff.op == OP_TICK) ? B_IDLE : B_DECIDE;
            end else begin
               sc_cnt_in = sc_cnt_ff + 1'b1;
            end
         end
         B_DECIDE: begin
            state_in = B_IDLE;
            if (cur_ff.op == OP_SEND) begin
               if (!sc_req_ff) begin
                  if (hit_ff) begin
                     res_in = make_rsp(KIND_IPV4_OUT, hit_mac_ff, '0, '0, cur_ff.tag, 1'b1);
                     state_in = B_EMIT;
                  end else begin
                     sc_req_in = 1'b1;
                     sc_cnt_in = '0;
                     hit_in = 1'b0;
                     free_in = 1'b0;
                     old_in = 1'b0;
                     state_in = B_SCAN;
                  end
               end else if (!(hit_ff && !((49'(hit_st_ff) + 49'(cfg.request_holdoff_ms))
                                          < 49'(now_ff)))) begin
                  r_we = 1'b1;
                  p_push = 1'b1;
                  res_in = make_rsp(KIND_ARP_REQ, BCAST_MAC, cur_ff.ip, '0, '0, 1'b1);
                  state_in = B_EMIT;
               end
            end else begin
               c_we = 1'b1;
               if (cur_ff.reply_us) begin
                  nres_in = '0;
                  held_in = 1'b0;
                  state_in = B_DRN_RD;
               end else if (cur_ff.req_us) begin
                  res_in = make_rsp(KIND_ARP_REP, cur_ff.mac, cur_ff.ip, cur_ff.mac, '0, 1'b1);
                  state_in = B_EMIT;
               end
            end
         end
         B_EMIT: begin
            if (out_free) begin
               out_load = 1'b1;
               out_data = res_ff;
               state_in = B_IDLE;
            end
         end
         B_DRN_RD: begin
            if (cnt_ff == '0 || nres_ff == RES_CNT_W'(MAX_RESULTS)) begin
               state_in = B_DRN_FIN;
            end else begin
               state_in = B_DRN_CMP;
            end
         end
         B_DRN_CMP: begin
            if (p_rd_ip_ff == cur_ff.ip) begin
               if (!held_ff || out_free) begin
                  if (held_ff) begin
                     out_load = 1'b1;
                     out_data = make_rsp(KIND_IPV4_OUT, cur_ff.mac, '0, '0, held_tag_ff, 1'b0);
                  end
                  held_in = 1'b1;
                  held_tag_in = p_rd_tag_ff;
                  p_pop = 1'b1;
                  nres_in = nres_ff + 1'b1;
                  state_in = B_DRN_RD;
               end
            end else begin
               state_in = B_DRN_FIN;
            end
         end
         B_DRN_FIN: begin
            held_in = 1'b0;
            if (held_ff) begin
               res_in = make_rsp(KIND_IPV4_OUT, cur_ff.mac, '0, '0, held_tag_ff, 1'b1);
               state_in = B_EMIT;
            end else begin
               state_in = B_IDLE;
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_comb begin
      head_in = head_ff;
      tail_in = tail_ff;
      cnt_in = cnt_ff;
      if (p_push) begin
         tail_in = (tail_ff == PI_W'(PENDING_DEPTH - 1)) ? '0 : tail_ff + 1'b1;
         if (cnt_ff == PC_W'(PENDING_DEPTH)) begin
            head_in = (head_ff == PI_W'(PENDING_DEPTH - 1)) ? '0 : head_ff + 1'b1;
         end else begin
            cnt_in = cnt_ff + 1'b1;
         end
      end else if (p_pop) begin
         head_in = (head_ff == PI_W'(PENDING_DEPTH - 1)) ? '0 : head_ff + 1'b1;
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_comb begin
      rsp_in = out_load ? out_data : rsp_ff;
      rsp_valid_in = out_load || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
         now_ff <= '0;
         c_valid_ff <= '0;
         r_valid_ff <= '0;
         head_ff <= '0;
         tail_ff <= '0;
         cnt_ff <= '0;
         held_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         now_ff <= now_in;
         head_ff <= head_in;
         tail_ff <= tail_in;
         cnt_ff <= cnt_in;
         held_ff <= held_in;
         rsp_valid_ff <= rsp_valid_in;
         if (c_we) begin
            c_valid_ff[c_waddr] <= 1'b1;
         end
         if (c_clr) begin
            c_valid_ff[c_clr_idx] <= 1'b0;
         end
         if (r_we) begin
            r_valid_ff[r_waddr] <= 1'b1;
         end
      end
      cur_ff <= cur_in;
      sc_cnt_ff <= sc_cnt_in;
      sc_req_ff <= sc_req_in;
      hit_ff <= hit_in;
      hit_idx_ff <= hit_idx_in;
      hit_st_ff <= hit_st_in;
      hit_mac_ff <= hit_mac_in;
      free_ff <= free_in;
      free_idx_ff <= free_idx_in;
      old_ff <= old_in;
      old_idx_ff <= old_idx_in;
      old_st_ff <= old_st_in;
      nres_ff <= nres_in;
      held_tag_ff <= held_tag_in;
      res_ff <= res_in;
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (c_we) begin
         c_ip_mem[c_waddr] <= cur_ff.ip;
         c_mac_mem[c_waddr] <= cur_ff.mac;
         c_st_mem[c_waddr] <= now_ff;
      end
      c_rd_ip_ff <= c_ip_mem[sc_cnt_ff[CI_W-1:0]];
      c_rd_mac_ff <= c_mac_mem[sc_cnt_ff[CI_W-1:0]];
      c_rd_st_ff <= c_st_mem[sc_cnt_ff[CI_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (r_we) begin
         r_ip_mem[r_waddr] <= cur_ff.ip;
         r_st_mem[r_waddr] <= now_ff;
      end
      r_rd_ip_ff <= r_ip_mem[sc_cnt_ff[RI_W-1:0]];
      r_rd_st_ff <= r_st_mem[sc_cnt_ff[RI_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (p_push) begin
         p_ip_mem[tail_ff] <= cur_ff.ip;
         p_tag_mem[tail_ff] <= cur_ff.tag;
      end
      p_rd_ip_ff <= p_ip_mem[head_ff];
      p_rd_tag_ff <= p_tag_mem[head_ff];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= PC_W'(PENDING_DEPTH))
      else $error("Pending count exceeds the queue depth.");

   a_empty_ptrs: assert property (@(posedge clock) disable iff (reset)
      cnt_ff == '0 |-> head_ff == tail_ff)
      else $error("Empty pending queue with unequal pointers.");

   a_idle_held: assert property (@(posedge clock) disable iff (reset)
      state_ff == B_IDLE |-> !held_ff)
      else $error("Held release result left over in idle.");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      p_pop |-> cnt_ff != '0)
      else $error("Pop from an empty pending queue.");

endmodule

FILE: src/arp_resolver_with_pending_queue_unit.sv
// An IPv4 delivery passes the front register, the queue and the emit state with no table scan;
// a cache hit or an answered ARP request first scans the cache, and a cache miss scans the cache
// and then the request table. An ARP reply releasing n datagrams drains matching entries from the
// pending queue head, up to MAX_RESULTS results. The back end takes a new transaction only in idle:
// after the emit for a delivery, the cache scan for a tick, the scans for a hit or miss, plus result stalls.
// Reset is synchronous and clears time, valid bits, the pending queue and all handshakes.
module arp_resolver_with_pending_queue_unit import arpr_pkg::*; #(
   parameter int CACHE_ENTRIES   = CACHE_ENTRIES_DEF,
   parameter int REQUEST_ENTRIES = REQUEST_ENTRIES_DEF,
   parameter int PENDING_DEPTH   = PENDING_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [47:0] csr_wdata
);

   cfg_type  cfg_ff, cfg_in;
   logic     f_valid, f_ready, q_valid, q_ready;
   item_type f_item, q_item;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_OWN_MAC:  cfg_in.own_mac = csr_wdata;
            CSR_OWN_IP:   cfg_in.own_ip = csr_wdata[31:0];
            CSR_LIFETIME: cfg_in.cache_lifetime_ms = csr_wdata[31:0];
            CSR_HOLDOFF:  cfg_in.request_holdoff_ms = csr_wdata[31:0];
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.own_mac <= '0;
         cfg_ff.own_ip <= '0;
         cfg_ff.cache_lifetime_ms <= LIFETIME_RST;
         cfg_ff.request_holdoff_ms <= HOLDOFF_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   arpr_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .item_valid (f_valid),
      .item_ready (f_ready),
      .item       (f_item)
   );

   arpr_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (f_valid),
      .in_ready  (f_ready),
      .in_item   (f_item),
      .out_valid (q_valid),
      .out_ready (q_ready),
      .out_item  (q_item)
   );

   arpr_back #(
      .CACHE_ENTRIES   (CACHE_ENTRIES),
      .REQUEST_ENTRIES (REQUEST_ENTRIES),
      .PENDING_DEPTH   (PENDING_DEPTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .item_valid (q_valid),
      .item_ready (q_ready),
      .item       (q_item),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

endmodule
